// File: src/sle_pkg.sv
// shared constants, codes and controller/datapath interface types
package sle_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int STAT_W   = 3;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 3'd0,
    OP_DELETE   = 3'd1,
    OP_LOCATE   = 3'd2,
    OP_UPDATE   = 3'd3,
    OP_TRAVERSE = 3'd4
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_BADPOS   = 3'd1,
    ST_FULL     = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  // what the result fields carry besides status and length
  typedef enum logic [1:0] {
    EK_PLAIN   = 2'd0,
    EK_REMOVED = 2'd1,
    EK_FOUND   = 2'd2,
    EK_ENTRY   = 2'd3
  } emit_kind_t;

  typedef struct packed {
    op_t        op;
    logic       load;
    logic       init;
    logic       issue;
    logic       shift;
    logic       write_val;
    logic       len_inc;
    logic       len_dec;
    logic       emit;
    status_t    status;
    emit_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic bad_pos;
    logic full;
    logic empty;
    logic more;
    logic rd_pend;
    logic hit;
    logic pend_last;
  } stat_t;

endpackage

// File: src/sequential_list_engine.sv
// top level of the ordered list engine: controller, datapath and checks
//
// usage
//   a request is transferred at a rising edge with start high and busy low;
//   opcode selects insert, delete, locate, update or traverse, position is
//   the 1-based list position, value the operand. unused opcodes are taken
//   and dropped without a result.
//   each result shows on status, value_res, position_res, length and last
//   for exactly one cycle with done high; last marks the final result of a
//   request. there is no back pressure, the receiver must take every result.
// sequence
//   update, rejected requests and an empty traverse give their result
//   straight from the check; insert and delete move the entries from the
//   position to the tail; locate stops early on the first match
//   traverse: one entry per cycle
//   busy stays high until the final result is issued. the walk over the
//   single store ram does one read and one write per cycle.
// reset
//   rst clears the length to zero and returns the sequencer to idle; store
//   contents are left as they are and only entries below the length are read.
module sequential_list_engine (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic        [sle_pkg::OP_W-1:0]    opcode,
  input  logic        [sle_pkg::LEN_W-1:0]   position,
  input  logic signed [sle_pkg::DATA_W-1:0]  value,
  output logic                               done,
  output logic        [sle_pkg::STAT_W-1:0]  status,
  output logic signed [sle_pkg::DATA_W-1:0]  value_res,
  output logic        [sle_pkg::LEN_W-1:0]   position_res,
  output logic        [sle_pkg::LEN_W-1:0]   length,
  output logic                               last
);
  import sle_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  sle_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  sle_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .position     (position),
    .value        (value),
    .stat         (stat),
    .done         (done),
    .status       (status),
    .value_res    (value_res),
    .position_res (position_res),
    .length       (length),
    .last         (last)
  );

  // a result only follows a cycle in which a request was in progress
  a_done_from_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result transfer without a request in progress");

  // the reported length never passes the store size
  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (length <= LEN_W'(CAPACITY)))
    else $error("list length beyond capacity");

  // a valid request always occupies the engine in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && opcode <= OP_TRAVERSE) |=> busy)
    else $error("request transfer did not start work");

  // the final result of a request is never directly followed by another one
  a_gap_after_last: assert property (@(posedge clk) disable iff (rst)
    (done && last) |=> !done)
    else $error("result transfer right after the final result");

endmodule

// File: src/sle_ram.sv
// generic simple dual-port ram with registered read
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/sle_ctrl.sv
// request sequencer: decodes the operation and steps the datapath
module sle_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [sle_pkg::OP_W-1:0]  opcode,
  input  sle_pkg::stat_t            stat,
  output sle_pkg::cmd_t             cmd,
  output logic                      busy
);
  import sle_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CHECK = 3'b010,
    S_SWEEP = 3'b100
  } state_t;

  state_t state, state_next;
  op_t    op;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op <= op_t'(opcode);
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.op     = op;
    cmd.status = ST_OK;
    cmd.kind   = EK_PLAIN;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          // unused codes give no result
          if (opcode <= OP_TRAVERSE) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        state_next = S_IDLE;
        unique case (op) inside
          OP_INSERT: begin
            if (stat.bad_pos) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_BADPOS;
            end else if (stat.full) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_FULL;
            end else begin
              cmd.init   = 1'b1;
              state_next = S_SWEEP;
            end
          end
          OP_DELETE: begin
            if (stat.bad_pos) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_BADPOS;
            end else begin
              cmd.init   = 1'b1;
              state_next = S_SWEEP;
            end
          end
          OP_LOCATE: begin
            cmd.init   = 1'b1;
            state_next = S_SWEEP;
          end
          OP_UPDATE: begin
            cmd.emit = 1'b1;
            if (stat.bad_pos) begin
              cmd.status = ST_BADPOS;
            end else begin
              cmd.write_val = 1'b1;
            end
          end
          OP_TRAVERSE: begin
            if (stat.empty) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_EMPTY;
            end else begin
              cmd.init   = 1'b1;
              state_next = S_SWEEP;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_SWEEP: begin
        cmd.issue = stat.more;
        unique case (op) inside
          OP_INSERT, OP_DELETE: begin
            cmd.shift = stat.rd_pend;
            if (!stat.more && !stat.rd_pend) begin
              cmd.emit   = 1'b1;
              state_next = S_IDLE;
              if (op == OP_INSERT) begin
                cmd.write_val = 1'b1;
                cmd.len_inc   = 1'b1;
              end else begin
                cmd.len_dec = 1'b1;
                cmd.kind    = EK_REMOVED;
              end
            end
          end
          OP_LOCATE: begin
            if (stat.hit) begin
              cmd.emit   = 1'b1;
              cmd.kind   = EK_FOUND;
              state_next = S_IDLE;
            end else if (!stat.more && !stat.rd_pend) begin
              cmd.emit   = 1'b1;
              cmd.status = ST_NOTFOUND;
              state_next = S_IDLE;
            end
          end
          OP_TRAVERSE: begin
            if (stat.rd_pend) begin
              cmd.emit = 1'b1;
              cmd.kind = EK_ENTRY;
            end
            if (!stat.more && !stat.rd_pend) begin
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: src/sle_datapath.sv
// list store, length, sweep cursor and result registers
module sle_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  sle_pkg::cmd_t                      cmd,
  input  logic        [sle_pkg::LEN_W-1:0]   position,
  input  logic signed [sle_pkg::DATA_W-1:0]  value,
  output sle_pkg::stat_t                     stat,
  output logic                               done,
  output logic        [sle_pkg::STAT_W-1:0]  status,
  output logic signed [sle_pkg::DATA_W-1:0]  value_res,
  output logic        [sle_pkg::LEN_W-1:0]   position_res,
  output logic        [sle_pkg::LEN_W-1:0]   length,
  output logic                               last
);
  import sle_pkg::*;

  logic [LEN_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  len_next;
  logic [LEN_W-1:0]  cursor;
  logic [LEN_W-1:0]  cursor_m1;
  logic [LEN_W-1:0]  pos_m1;
  logic [IDX_W-1:0]  pos_idx;
  logic              rd_pend;
  logic [IDX_W-1:0]  rd_addr_q;
  logic [LEN_W-1:0]  pend_pos;
  logic [DATA_W-1:0] removed;
  logic              is_insert;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;
  logic [IDX_W-1:0]  raddr;
  logic [DATA_W-1:0] rdata;

  assign is_insert = (cmd.op == OP_INSERT);
  assign pos_m1    = pos_q - LEN_W'(1);
  assign pos_idx   = pos_m1[IDX_W-1:0];
  assign cursor_m1 = cursor - LEN_W'(1);
  assign pend_pos  = LEN_W'(rd_addr_q) + LEN_W'(1);
  assign len_next  = len + LEN_W'(cmd.len_inc) - LEN_W'(cmd.len_dec);

  // insert walks down from the tail, delete walks up from its position, the rest up from the head
  assign raddr = is_insert ? cursor_m1[IDX_W-1:0] : cursor[IDX_W-1:0];

  always_comb begin
    stat.bad_pos   = (pos_q == '0) || (is_insert ? (pos_m1 > len) : (pos_q > len));
    stat.full      = (len == LEN_W'(CAPACITY));
    stat.empty     = (len == '0);
    stat.more      = is_insert ? (cursor >= pos_q) : (cursor < len);
    stat.rd_pend   = rd_pend;
    stat.hit       = rd_pend && (rdata == val_q);
    stat.pend_last = (pend_pos == len);
  end

  always_comb begin
    we    = 1'b0;
    waddr = pos_idx;
    wdata = val_q;
    if (cmd.write_val) begin
      we = 1'b1;
    end else if (cmd.shift) begin
      if (is_insert) begin
        we    = 1'b1;
        waddr = rd_addr_q + IDX_W'(1);
        wdata = rdata;
      end else if (rd_addr_q != pos_idx) begin
        we    = 1'b1;
        waddr = rd_addr_q - IDX_W'(1);
        wdata = rdata;
      end
    end
  end

  sle_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (cmd.issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pos_q <= position;
      val_q <= value;
    end
    if (cmd.init) begin
      case (cmd.op)
        OP_INSERT: cursor <= len;
        OP_DELETE: cursor <= pos_m1;
        default:   cursor <= '0;
      endcase
    end else if (cmd.issue) begin
      cursor <= is_insert ? cursor_m1 : cursor + LEN_W'(1);
    end
    if (cmd.issue) begin
      rd_addr_q <= raddr;
    end
    // delete reads its own entry first and keeps it for the result
    if (cmd.shift && !is_insert && rd_addr_q == pos_idx) begin
      removed <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      len     <= len_next;
      rd_pend <= cmd.issue;
      done    <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status       <= cmd.status;
      length       <= len_next;
      value_res    <= '0;
      position_res <= '0;
      last         <= 1'b1;
      case (cmd.kind)
        EK_REMOVED: value_res <= removed;
        EK_FOUND:   position_res <= pend_pos;
        EK_ENTRY: begin
          value_res    <= rdata;
          position_res <= pend_pos;
          last         <= stat.pend_last;
        end
        default: ;
      endcase
    end
  end

endmodule
